FILE: sv/julian_day_to_calendar_date_top_macros.svh
// Assertion macros for the julian day to calendar date port checker
`ifndef JULIAN_DAY_TO_CALENDAR_DATE_TOP_MACROS_SVH
`define JULIAN_DAY_TO_CALENDAR_DATE_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset
`define JDCD_AST_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("jdcd check failed");

// Next-cycle implication, disabled during reset
`define JDCD_AST_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("jdcd check failed");

`endif

FILE: sv/jdcd_pkg.sv
// Types, constants and tables for the julian day to calendar date converter
package jdcd_pkg;

    // Field widths
    localparam int DAY_W   = 23;
    localparam int FRAC_W  = 32;
    localparam int YEAR_W  = 16;
    localparam int MONTH_W = 4;
    localparam int DOM_W   = 5;
    localparam int HOUR_W  = 32;

    // Input item
    typedef struct packed {
        logic [DAY_W-1:0]  day_number;
        logic [FRAC_W-1:0] day_fraction;
    } t_in;

    // Result item
    typedef struct packed {
        logic signed [YEAR_W-1:0] year;
        logic [MONTH_W-1:0]       month;
        logic [DOM_W-1:0]         day_of_month;
        logic [HOUR_W-1:0]        hour_of_day;
    } t_out;

    // First day of the Gregorian calendar
    localparam longint GREG_START = 2299161;

    // alpha = floor((4Z - ALPHA_OFS) / ALPHA_DIV)
    localparam longint ALPHA_OFS = 7468865;
    localparam longint ALPHA_DIV = 146097;

    // B = A + B_OFS; Gregorian path folds the +1 in
    localparam longint B_OFS      = 1524;
    localparam longint B_OFS_GREG = 1525;

    // C = floor((20B - C_OFS) / C_DIV)
    localparam longint C_OFS = 2442;
    localparam longint C_DIV = 7305;

    // D = floor(D_MUL * C / 4)
    localparam longint D_MUL = 1461;

    // E = floor(E_NUM * X / E_DIV), X = B - D
    localparam int     X_W    = 10;
    localparam int     E_W    = 4;
    localparam longint E_NUM  = 10000;
    localparam longint E_DIV  = 306001;
    localparam int     E_SH   = 16;
    localparam longint E_RCP  = ((64'd1 << E_SH) * E_NUM) / E_DIV;
    localparam int     E_RW   = 12;
    localparam int     E_PW   = X_W + E_RW;
    localparam int     E_NW   = 24;

    // Month and year adjustment
    localparam logic [E_W-1:0]     E_WRAP      = 4'd14;
    localparam logic [E_W-1:0]     E_OFS_LO    = 4'd1;
    localparam logic [E_W-1:0]     E_OFS_HI    = 4'd13;
    localparam logic [MONTH_W-1:0] MONTH_FEB   = 4'd2;
    localparam longint             YEAR_OFS_LO = 4716;
    localparam longint             YEAR_OFS_HI = 4715;

    // floor(306001 * e / 10000), days before month index e
    function automatic logic [8:0] e_offset(input logic [E_W-1:0] e);
        logic [8:0] v;
        unique case (e)
            4'd0:  v = 9'd0;
            4'd1:  v = 9'd30;
            4'd2:  v = 9'd61;
            4'd3:  v = 9'd91;
            4'd4:  v = 9'd122;
            4'd5:  v = 9'd153;
            4'd6:  v = 9'd183;
            4'd7:  v = 9'd214;
            4'd8:  v = 9'd244;
            4'd9:  v = 9'd275;
            4'd10: v = 9'd306;
            4'd11: v = 9'd336;
            4'd12: v = 9'd367;
            4'd13: v = 9'd397;
            4'd14: v = 9'd428;
            4'd15: v = 9'd459;
        endcase
        return v;
    endfunction

endpackage

FILE: sv/julian_day_to_calendar_date_top.sv
// Julian day number and day fraction to calendar date and hour, deep pipeline
//
//  channel | valid   | stall   | payload
//  --------+---------+---------+--------------------------
//  input   | i_valid | o_stall | i_data (t_in)
//  output  | o_valid | i_stall | o_data (t_out)
//
// One item is taken every cycle while the result is not stalled.
// The depth comes from three divide-by-constant steps, each a reciprocal
// multiply, a back-multiply and a one-step correction in stages of their own.
// Reset clears only the stage valid bits.
// A stalled result freezes the whole pipe; nothing is dropped or repeated.
module julian_day_to_calendar_date_top
    import jdcd_pkg::*;
#(
    parameter int DAY_NUMBER_BITS = 23
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_in  i_data,
    output logic o_valid,
    input  logic i_stall,
    output t_out o_data
);

    localparam int NS  = 15;
    localparam int ZW  = DAY_NUMBER_BITS;
    localparam int ZU  = (ZW < DAY_W) ? ZW : DAY_W;
    // alpha division
    localparam int NW1 = ZW + 2;
    localparam int MW1 = NW1 - 16;
    localparam int PW1 = NW1 + MW1;
    localparam longint unsigned M1 = (64'd1 << NW1) / ALPHA_DIV;
    // B and C division
    localparam int BW  = ZW + 1;
    localparam int NW2 = BW + 5;
    localparam int CW  = NW2 - 12;
    localparam int PW2 = NW2 + CW;
    localparam longint unsigned M2 = (64'd1 << NW2) / C_DIV;
    // D and X
    localparam int DPW = CW + 11;
    localparam int DW  = DPW - 2;
    localparam int YW  = CW + 1;

    // Pipeline advance
    logic          en;
    logic [NS-1:0] r_vld;

    assign en      = !(r_vld[NS-1] && i_stall);
    assign o_stall = !en;
    assign o_valid = r_vld[NS-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NS-2:0], i_valid};
        end
    end

    // Stage registers
    logic [ZW-1:0]     r1_z, r2_z, r3_z, r4_z;
    logic              r1_greg, r2_greg, r3_greg, r4_greg;
    logic [NW1-1:0]    r1_n, r2_n, r3_n, r3_m;
    logic [PW1-1:0]    r2_p;
    logic [MW1-1:0]    r3_q, r4_alpha;
    logic [BW-1:0]     r5_b, r6_b, r7_b, r8_b, r9_b, r10_b;
    logic [NW2-1:0]    r6_n, r7_n, r8_n, r8_m;
    logic [PW2-1:0]    r7_p;
    logic [CW-1:0]     r8_q, r9_c, r10_c, r11_c, r12_c, r13_c, r14_c;
    logic [DW-1:0]     r10_d;
    logic [X_W-1:0]    r11_x, r12_x, r13_x, r14_x;
    logic [E_PW-1:0]   r12_p;
    logic [E_NW-1:0]   r12_n, r13_n, r13_m;
    logic [E_W-1:0]    r13_e, r14_e;
    logic [HOUR_W-1:0] r_hour [NS-1];
    t_out              r_out;

    // Combinational helpers
    logic [ZW-1:0]      z_in;
    logic [FRAC_W+4:0]  frac24;
    logic [MW1-1:0]     q1;
    logic               fix1;
    logic [CW-1:0]      q2;
    logic               fix2;
    logic [DPW-1:0]     d_prod;
    logic [ZW+2:0]      x_full;
    logic [E_W-1:0]     e0;
    logic               fix3;
    logic [MONTH_W-1:0] month;
    logic [YW-1:0]      year_full;
    logic [X_W-1:0]     dom_full;

    assign z_in   = ZW'(i_data.day_number[ZU-1:0]);
    // fraction times 24 as 16x + 8x
    assign frac24 = {1'b0, i_data.day_fraction, 4'b0000}
                  + {2'b00, i_data.day_fraction, 3'b000};
    assign q1     = r2_p[PW1-1:NW1];
    assign fix1   = ({1'b0, r3_n} >= ({1'b0, r3_m} + (NW1+1)'(ALPHA_DIV)));
    assign q2     = r7_p[PW2-1:NW2];
    assign fix2   = ({1'b0, r8_n} >= ({1'b0, r8_m} + (NW2+1)'(C_DIV)));
    assign d_prod = DPW'(r9_c) * DPW'(D_MUL);
    assign x_full = (ZW+3)'(r10_b) - (ZW+3)'(r10_d);
    assign e0     = r12_p[E_SH+E_W-1:E_SH];
    assign fix3   = ({1'b0, r13_n} >= ({1'b0, r13_m} + (E_NW+1)'(E_DIV)));

    // Month, year and day from E
    assign month     = (r14_e < E_WRAP) ? (r14_e - E_OFS_LO) : (r14_e - E_OFS_HI);
    assign year_full = (month > MONTH_FEB) ? (YW'(r14_c) - YW'(YEAR_OFS_LO))
                                           : (YW'(r14_c) - YW'(YEAR_OFS_HI));
    assign dom_full  = r14_x - X_W'(e_offset(r14_e));

    // Hour travels alongside the date stages
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_hour[0] <= frac24[FRAC_W+4:5];
            for (int k = 1; k < NS - 1; k++) begin
                r_hour[k] <= r_hour[k-1];
            end
        end
    end

    // Date datapath
    always_ff @(posedge i_clk) begin
        if (en) begin
            // S1: Gregorian flag and alpha numerator
            r1_z    <= z_in;
            r1_greg <= (z_in >= ZW'(GREG_START));
            r1_n    <= {z_in, 2'b00} - NW1'(ALPHA_OFS);
            // S2: reciprocal multiply
            r2_p    <= PW1'(r1_n) * PW1'(M1);
            r2_n    <= r1_n;
            r2_z    <= r1_z;
            r2_greg <= r1_greg;
            // S3: estimate and back-multiply
            r3_q    <= q1;
            r3_m    <= NW1'(q1) * NW1'(ALPHA_DIV);
            r3_n    <= r2_n;
            r3_z    <= r2_z;
            r3_greg <= r2_greg;
            // S4: correct alpha
            r4_alpha <= r3_q + MW1'(fix1);
            r4_z     <= r3_z;
            r4_greg  <= r3_greg;
            // S5: B
            r5_b <= r4_greg ? (BW'(r4_z) + BW'(B_OFS_GREG) + BW'(r4_alpha)
                               - BW'(r4_alpha >> 2))
                            : (BW'(r4_z) + BW'(B_OFS));
            // S6: C numerator, 20B as 16B + 4B
            r6_n <= (NW2'(r5_b) << 4) + (NW2'(r5_b) << 2) - NW2'(C_OFS);
            r6_b <= r5_b;
            // S7: reciprocal multiply
            r7_p <= PW2'(r6_n) * PW2'(M2);
            r7_n <= r6_n;
            r7_b <= r6_b;
            // S8: estimate and back-multiply
            r8_q <= q2;
            r8_m <= NW2'(q2) * NW2'(C_DIV);
            r8_n <= r7_n;
            r8_b <= r7_b;
            // S9: correct C
            r9_c <= r8_q + CW'(fix2);
            r9_b <= r8_b;
            // S10: D
            r10_d <= d_prod[DPW-1:2];
            r10_c <= r9_c;
            r10_b <= r9_b;
            // S11: X = B - D, small by construction
            r11_x <= x_full[X_W-1:0];
            r11_c <= r10_c;
            // S12: E numerator and reciprocal multiply
            r12_p <= E_PW'(r11_x) * E_PW'(E_RCP);
            r12_n <= E_NW'(r11_x) * E_NW'(E_NUM);
            r12_x <= r11_x;
            r12_c <= r11_c;
            // S13: estimate and back-multiply
            r13_e <= e0;
            r13_m <= E_NW'(e0) * E_NW'(E_DIV);
            r13_n <= r12_n;
            r13_x <= r12_x;
            r13_c <= r12_c;
            // S14: correct E
            r14_e <= r13_e + E_W'(fix3);
            r14_x <= r13_x;
            r14_c <= r13_c;
            // S15: result item
            r_out.year         <= year_full[YEAR_W-1:0];
            r_out.month        <= month;
            r_out.day_of_month <= dom_full[DOM_W-1:0];
            r_out.hour_of_day  <= r_hour[NS-2];
        end
    end

    assign o_data = r_out;

endmodule

FILE: sv/jdcd_chk.sv
// Port checker for the julian day to calendar date converter, with its bind
`include "julian_day_to_calendar_date_top_macros.svh"

module jdcd_chk
    import jdcd_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic o_stall,
    input logic o_valid,
    input logic i_stall,
    input t_out o_data
);

    // A stalled result holds
    `JDCD_AST_NXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_data))

    // Input backpressure only comes from a blocked result
    `JDCD_AST_IMP(a_stall_cause, i_clk, i_rst_n, o_stall, o_valid && i_stall)

    // Month within January to December
    `JDCD_AST_IMP(a_month_rng, i_clk, i_rst_n, o_valid, o_data.month != 4'd0 && o_data.month <= 4'd12)

    // Day of month never zero
    `JDCD_AST_IMP(a_dom_nz, i_clk, i_rst_n, o_valid, o_data.day_of_month != 5'd0)

    // Hour stays below 24
    `JDCD_AST_IMP(a_hour_rng, i_clk, i_rst_n, o_valid, o_data.hour_of_day[31:30] != 2'b11)

endmodule

bind julian_day_to_calendar_date_top jdcd_chk u_jdcd_chk (.*);
